@@ hdl/mtwg_pkg.sv @@
// Shared constants, payload types and control types of the MT19937 word generator.
package mtwg_pkg;

    // Generator geometry
    localparam int unsigned STATE_WORDS    = 624;
    localparam int unsigned SHIFT_DISTANCE = 397;
    localparam int unsigned FAR_WRAP       = STATE_WORDS - SHIFT_DISTANCE;
    localparam int unsigned ADDR_W         = $clog2(STATE_WORDS);
    localparam int unsigned POS_W          = $clog2(STATE_WORDS + 1);
    localparam int unsigned WORD_W         = 32;
    localparam int unsigned HALF_W         = WORD_W / 2;

    // Arithmetic constants
    localparam logic [WORD_W-1:0] LCG_MUL   = 32'h0001_0dcd;
    localparam logic [WORD_W-1:0] TWIST_MAG = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] HIGH_BIT  = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LOW_BITS  = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] TEMPER_B  = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C  = 32'hefc6_0000;

    // Request codes
    typedef enum logic {
        ACT_NEXT   = 1'b0,
        ACT_RESEED = 1'b1
    } action_t;

    // Channel payloads
    typedef struct packed {
        action_t             action;
        logic [WORD_W-1:0]   seed_value;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0]   random_word;
        logic                not_seeded;
    } rsp_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_HI,
        ST_SEED_LO,
        ST_TW_FIRST,
        ST_TW_CARRY,
        ST_TW_RD,
        ST_TW_WR,
        ST_TW_DONE,
        ST_RD_ISSUE,
        ST_RD_OUT,
        ST_NS_OUT
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic x_load;
        logic x_step;
        logic hi_load;
        logic seed_write;
        logic k_clear;
        logic k_inc;
        logic rd_first;
        logic rd_twist;
        logic carry_load;
        logic twist_write;
        logic pos_clear;
        logic pos_inc;
        logic seeded_set;
        logic out_load_word;
        logic out_load_ns;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic k_last;
        logic pos_full;
        logic seeded;
        logic out_free;
    } stat_t;

endpackage

@@ hdl/mtwg_stream_if.sv @@
// Valid/ready stream channel with a typed payload.
interface mtwg_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/mtwg_ram.sv @@
// Generic RAM: one write port, two read ports, registered read data.
module mtwg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ hdl/mtwg_ctrl.sv @@
// Controller state machine: sequences seeding, twisting and word reads.
module mtwg_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  mtwg_pkg::action_t in_action,
    output logic              in_ready,
    input  mtwg_pkg::stat_t   stat,
    output mtwg_pkg::cmd_t    cmd
);

    import mtwg_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   from_next_reg;
    logic   from_next_next;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            from_next_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            from_next_reg <= from_next_next;
        end
    end

    // Next-state logic
    always_comb
    begin
        state_next     = state_reg;
        from_next_next = from_next_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_action == ACT_RESEED)
                    begin
                        state_next     = ST_SEED_HI;
                        from_next_next = 1'b0;
                    end
                    else if (!stat.seeded)
                    begin
                        state_next = ST_NS_OUT;
                    end
                    else if (stat.pos_full)
                    begin
                        state_next     = ST_TW_FIRST;
                        from_next_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_RD_ISSUE;
                    end
                end
            end
            ST_SEED_HI:
            begin
                state_next = ST_SEED_LO;
            end
            ST_SEED_LO:
            begin
                state_next = stat.k_last ? ST_TW_FIRST : ST_SEED_HI;
            end
            ST_TW_FIRST:
            begin
                state_next = ST_TW_CARRY;
            end
            ST_TW_CARRY:
            begin
                state_next = ST_TW_WR;
            end
            ST_TW_RD:
            begin
                state_next = ST_TW_WR;
            end
            ST_TW_WR:
            begin
                state_next = stat.k_last ? ST_TW_DONE : ST_TW_RD;
            end
            ST_TW_DONE:
            begin
                state_next = from_next_reg ? ST_RD_ISSUE : ST_IDLE;
            end
            ST_RD_ISSUE:
            begin
                state_next = ST_RD_OUT;
            end
            ST_RD_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_NS_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_action == ACT_RESEED)
                    begin
                        cmd.x_load  = 1'b1;
                        cmd.k_clear = 1'b1;
                    end
                    else if (stat.seeded && stat.pos_full)
                    begin
                        cmd.k_clear = 1'b1;
                    end
                end
            end
            ST_SEED_HI:
            begin
                cmd.hi_load = 1'b1;
                cmd.x_step  = 1'b1;
            end
            ST_SEED_LO:
            begin
                cmd.seed_write = 1'b1;
                cmd.x_step     = 1'b1;
                cmd.k_clear    = stat.k_last;
                cmd.k_inc      = !stat.k_last;
            end
            ST_TW_FIRST:
            begin
                cmd.rd_first = 1'b1;
            end
            ST_TW_CARRY:
            begin
                cmd.carry_load = 1'b1;
                cmd.rd_twist   = 1'b1;
            end
            ST_TW_RD:
            begin
                cmd.rd_twist = 1'b1;
            end
            ST_TW_WR:
            begin
                cmd.twist_write = 1'b1;
                cmd.k_clear     = stat.k_last;
                cmd.k_inc       = !stat.k_last;
            end
            ST_TW_DONE:
            begin
                cmd.pos_clear  = 1'b1;
                cmd.seeded_set = !from_next_reg;
            end
            ST_RD_ISSUE:
            begin
                cmd = '0;
            end
            ST_RD_OUT:
            begin
                cmd.out_load_word = stat.out_free;
                cmd.pos_inc       = stat.out_free;
            end
            ST_NS_OUT:
            begin
                cmd.out_load_ns = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // A reseed beat always starts the seeding sweep.
    a_reseed_starts_seeding: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_action == ACT_RESEED) |=> state_reg == ST_SEED_HI)
        else $error("reseed beat did not start seeding");

    // The twist that closes a seeding sweep leaves the generator seeded.
    a_seed_twist_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TW_DONE && !from_next_reg) |=> stat.seeded)
        else $error("seeding finished without setting the seeded flag");

endmodule

@@ hdl/mtwg_datapath.sv @@
// Datapath: state memory, LCG seeder, twist unit, tempering and result register.
module mtwg_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mtwg_pkg::cmd_t                cmd,
    output mtwg_pkg::stat_t               stat,
    input  logic [mtwg_pkg::WORD_W-1:0]   seed_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mtwg_pkg::WORD_W-1:0]   out_word,
    output logic                          out_ns
);

    import mtwg_pkg::*;

    logic [WORD_W-1:0] x_reg;
    logic [WORD_W-1:0] x_next;
    logic [HALF_W-1:0] hi_reg;
    logic [HALF_W-1:0] hi_next;
    logic [ADDR_W-1:0] k_reg;
    logic [ADDR_W-1:0] k_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [WORD_W-1:0] carry_reg;
    logic [WORD_W-1:0] carry_next;
    logic              seeded_reg;
    logic              seeded_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [WORD_W-1:0] out_word_reg;
    logic [WORD_W-1:0] out_word_next;
    logic              out_ns_reg;
    logic              out_ns_next;

    logic [WORD_W-1:0] lcg_prod;
    logic [WORD_W-1:0] lcg_value;
    logic              k_last;
    logic              pos_full;
    logic              out_free;
    logic [ADDR_W-1:0] nxt_addr;
    logic [ADDR_W-1:0] far_addr;
    logic [ADDR_W-1:0] raddr_a;
    logic              ram_we;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] rdata_a;
    logic [WORD_W-1:0] rdata_b;
    logic [WORD_W-1:0] twist_y;
    logic [WORD_W-1:0] twist_v;

    // Output tempering of one state word
    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] y_in);
        logic [WORD_W-1:0] y;
        y = y_in;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    // Status toward the controller
    assign k_last   = (k_reg == ADDR_W'(STATE_WORDS - 1));
    assign pos_full = (pos_reg == POS_W'(STATE_WORDS));
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        stat.k_last   = k_last;
        stat.pos_full = pos_full;
        stat.seeded   = seeded_reg;
        stat.out_free = out_free;
    end

    // Linear congruential step of the seeder
    assign lcg_prod  = x_reg * LCG_MUL;
    assign lcg_value = lcg_prod + 32'd1;

    // Neighbor and far addresses of the word being twisted
    assign nxt_addr = k_last ? '0 : k_reg + ADDR_W'(1);
    assign far_addr = (k_reg < ADDR_W'(FAR_WRAP)) ? k_reg + ADDR_W'(SHIFT_DISTANCE)
                                                 : k_reg - ADDR_W'(FAR_WRAP);

    // Read address A serves the twist and the word reads
    always_comb
    begin
        if (cmd.rd_twist)
        begin
            raddr_a = nxt_addr;
        end
        else if (cmd.rd_first || pos_full)
        begin
            raddr_a = '0;
        end
        else
        begin
            raddr_a = pos_reg[ADDR_W-1:0];
        end
    end

    // Twist of one word: upper bit of the old word, lower bits of its neighbor
    assign twist_y = (carry_reg & HIGH_BIT) | (rdata_a & LOW_BITS);
    assign twist_v = rdata_b ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_MAG : '0);

    // Memory write port
    assign ram_we    = cmd.seed_write || cmd.twist_write;
    assign ram_wdata = cmd.seed_write ? {hi_reg, x_reg[WORD_W-1:HALF_W]} : twist_v;

    mtwg_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STATE_WORDS)
    ) u_state_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (k_reg),
        .wdata   (ram_wdata),
        .raddr_a (raddr_a),
        .raddr_b (far_addr),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // Next values of the datapath registers
    always_comb
    begin
        x_next         = x_reg;
        hi_next        = hi_reg;
        k_next         = k_reg;
        pos_next       = pos_reg;
        carry_next     = carry_reg;
        seeded_next    = seeded_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        out_ns_next    = out_ns_reg;

        if (cmd.x_load)
        begin
            x_next = seed_in;
        end
        else if (cmd.x_step)
        begin
            x_next = lcg_value;
        end
        if (cmd.hi_load)
        begin
            hi_next = x_reg[WORD_W-1:HALF_W];
        end
        if (cmd.k_clear)
        begin
            k_next = '0;
        end
        else if (cmd.k_inc)
        begin
            k_next = k_reg + ADDR_W'(1);
        end
        if (cmd.pos_clear)
        begin
            pos_next = '0;
        end
        else if (cmd.pos_inc)
        begin
            pos_next = pos_reg + POS_W'(1);
        end
        if (cmd.carry_load || cmd.twist_write)
        begin
            carry_next = rdata_a;
        end
        if (cmd.seeded_set)
        begin
            seeded_next = 1'b1;
        end

        // Result register: a loaded beat waits until the receiver takes it
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load_word)
        begin
            out_valid_next = 1'b1;
            out_word_next  = temper(rdata_a);
            out_ns_next    = 1'b0;
        end
        else if (cmd.out_load_ns)
        begin
            out_valid_next = 1'b1;
            out_word_next  = '0;
            out_ns_next    = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            seeded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            pos_reg       <= pos_next;
            seeded_reg    <= seeded_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        hi_reg       <= hi_next;
        carry_reg    <= carry_next;
        out_word_reg <= out_word_next;
        out_ns_reg   <= out_ns_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_ns    = out_ns_reg;

    // The read position only advances inside the current block of words.
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pos_inc |-> !pos_full)
        else $error("read position advanced past the end of the state");

    // A result is only loaded into a free result register.
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load_word || cmd.out_load_ns) |-> out_free)
        else $error("result register overwritten before it was taken");

    // A tempered word is only produced from a seeded state.
    a_word_needs_seed: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load_word |-> seeded_reg)
        else $error("word produced before seeding");

    // Seeding and twisting never write the state memory in the same cycle.
    a_single_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.seed_write && cmd.twist_write))
        else $error("seed write and twist write in the same cycle");

endmodule

@@ hdl/mt19937_word_generator_unit.sv @@
// Top level of the MT19937 word generator: controller plus datapath.
//
// Usage: requests arrive on the req channel (action, seed_value) and results
// leave on the rsp channel (random_word, not_seeded); a beat moves when valid
// and ready are both high. A reseed beat yields no result; a next beat yields
// exactly one.
// Seeding fills the 624-word state (one LCG multiply per cycle), then twists
// it word by word through the two-read, one-write state memory; req is not
// ready while seeding and twisting run.
// A next request runs from accept to a loaded result through accept, memory
// read, and temper into the result register; the last step waits until the
// result register is free. The request that finds all 624 words used first
// runs a twist before its read.
// A next request before any seed returns zero with not_seeded set.
// Reset clears the read position, the seeded flag and the result valid flag;
// the state memory keeps no reset value and is written by seeding.
// A stalled receiver holds the result in its register; the block still
// accepts the next request, and waits only when it has a new result ready.
module mt19937_word_generator_unit (
    input  logic          clk,
    input  logic          rst_n,
    mtwg_stream_if.sink   req,
    mtwg_stream_if.source rsp
);

    import mtwg_pkg::*;

    cmd_t              cmd;
    stat_t             stat;
    action_t           req_action;
    logic [WORD_W-1:0] req_seed;
    logic [WORD_W-1:0] rsp_word;
    logic              rsp_ns;

    assign req_action = req.payload.action;
    assign req_seed   = req.payload.seed_value;

    // Sequencer
    mtwg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_action (req_action),
        .in_ready  (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // State memory, arithmetic and result register
    mtwg_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .seed_in   (req_seed),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_word  (rsp_word),
        .out_ns    (rsp_ns)
    );

    assign rsp.payload.random_word = rsp_word;
    assign rsp.payload.not_seeded  = rsp_ns;

endmodule
